@@ src/button_code_lock_controller_macros.svh @@
// Assertion macros used by the checker file of the lock controller.
// Each macro samples on aclk and is switched off while aresetn is low.
`ifndef BUTTON_CODE_LOCK_CONTROLLER_MACROS_SVH
`define BUTTON_CODE_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define BLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lock controller check failed");

// Next-cycle implication.
`define BLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lock controller check failed");

`endif

@@ src/blc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

    // Fixed widths of the fields and registers.
    localparam int TICK_W       = 16;
    localparam int LED_W        = 16;
    localparam int IDX_W        = 5;
    localparam int LEN_W        = 5;
    localparam int SEQ_W        = 40;
    localparam int BTN_W        = 3;
    localparam int KEY_W        = 2;
    localparam int BAR_LSB      = 5;

    // Code storage: two bits per entry, twenty entries in the sequence word.
    localparam int CODE_ENTRIES = 20;
    localparam int CODE_MAX_LEN = 20;

    // Register port.
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;
    localparam int REG_IDX_W    = 3;

    // Shift-subtract remainder unit.
    localparam int MOD_STEPS    = 16;
    localparam int MOD_CNT_W    = 4;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_CODE_LENGTH     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CODE_SEQUENCE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_LED_MASK   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_PERIOD     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNLOCK_DURATION = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOCK_DURATION   = 3'd5;

    // Register reset values.
    localparam logic [LEN_W-1:0]  RST_CODE_LENGTH     = 5'd4;
    localparam logic [SEQ_W-1:0]  RST_CODE_SEQUENCE   = 40'd38;
    localparam logic [LED_W-1:0]  RST_BASE_LED_MASK   = 16'hF81F;
    localparam logic [TICK_W-1:0] RST_STEP_PERIOD     = 16'd8;
    localparam logic [TICK_W-1:0] RST_UNLOCK_DURATION = 16'd40;
    localparam logic [TICK_W-1:0] RST_LOCK_DURATION   = 16'd40;

    // Button codes on the input word.
    localparam logic [BTN_W-1:0] BTN_NONE = 3'd0;
    localparam logic [BTN_W-1:0] BTN_A    = 3'd1;
    localparam logic [BTN_W-1:0] BTN_B    = 3'd2;
    localparam logic [BTN_W-1:0] BTN_X    = 3'd3;
    localparam logic [BTN_W-1:0] BTN_Y    = 3'd4;

    // Key codes inside the secret code.
    localparam logic [KEY_W-1:0] KEY_A = 2'd0;
    localparam logic [KEY_W-1:0] KEY_B = 2'd1;
    localparam logic [KEY_W-1:0] KEY_Y = 2'd2;

    typedef enum logic [1:0] {
        PH_LOCKED    = 2'd0,
        PH_UNLOCKING = 2'd1,
        PH_UNLOCKED  = 2'd2,
        PH_LOCKING   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_EXEC = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  code_length;
        logic [SEQ_W-1:0]  code_sequence;
        logic [LED_W-1:0]  base_led_mask;
        logic [TICK_W-1:0] step_period;
        logic [TICK_W-1:0] unlock_duration;
        logic [TICK_W-1:0] lock_duration;
    } cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic mod_step;
        logic mod_last;
        logic exec;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic stale;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/blc_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blc_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [blc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [blc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [blc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output blc_pkg::cfg_t                     cfg,
    output logic                              period_wr
);
    import blc_pkg::*;

    logic [LEN_W-1:0]     code_length_reg;
    logic [SEQ_W-1:0]     code_sequence_reg;
    logic [LED_W-1:0]     base_led_mask_reg;
    logic [TICK_W-1:0]    step_period_reg;
    logic [TICK_W-1:0]    unlock_duration_reg;
    logic [TICK_W-1:0]    lock_duration_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_idx   = paddr[APB_ADDR_W-1:3];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign period_wr = wr_en && (reg_idx == REG_STEP_PERIOD);

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_length_reg     <= RST_CODE_LENGTH;
            code_sequence_reg   <= RST_CODE_SEQUENCE;
            base_led_mask_reg   <= RST_BASE_LED_MASK;
            step_period_reg     <= RST_STEP_PERIOD;
            unlock_duration_reg <= RST_UNLOCK_DURATION;
            lock_duration_reg   <= RST_LOCK_DURATION;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CODE_LENGTH:     code_length_reg     <= pwdata[LEN_W-1:0];
                REG_CODE_SEQUENCE:   code_sequence_reg   <= pwdata[SEQ_W-1:0];
                REG_BASE_LED_MASK:   base_led_mask_reg   <= pwdata[LED_W-1:0];
                REG_STEP_PERIOD:     step_period_reg     <= pwdata[TICK_W-1:0];
                REG_UNLOCK_DURATION: unlock_duration_reg <= pwdata[TICK_W-1:0];
                REG_LOCK_DURATION:   lock_duration_reg   <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            REG_CODE_LENGTH:     prdata = APB_DATA_W'(code_length_reg);
            REG_CODE_SEQUENCE:   prdata = APB_DATA_W'(code_sequence_reg);
            REG_BASE_LED_MASK:   prdata = APB_DATA_W'(base_led_mask_reg);
            REG_STEP_PERIOD:     prdata = APB_DATA_W'(step_period_reg);
            REG_UNLOCK_DURATION: prdata = APB_DATA_W'(unlock_duration_reg);
            REG_LOCK_DURATION:   prdata = APB_DATA_W'(lock_duration_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.code_length     = code_length_reg;
    assign cfg.code_sequence   = code_sequence_reg;
    assign cfg.base_led_mask   = base_led_mask_reg;
    assign cfg.step_period     = step_period_reg;
    assign cfg.unlock_duration = unlock_duration_reg;
    assign cfg.lock_duration   = lock_duration_reg;

endmodule

`default_nettype wire

@@ src/blc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  blc_pkg::dp_status_t status,
    output blc_pkg::dp_cmd_t    cmd
);
    import blc_pkg::*;

    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;

    // Sequencing: take a word, rebuild the remainder if needed, then commit.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (status.stale) begin
                        state_next = ST_MOD;
                        cnt_next   = MOD_CNT_W'(MOD_STEPS - 1);
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == '0) begin
                    cmd.mod_last = 1'b1;
                    state_next   = ST_EXEC;
                end else begin
                    cnt_next = cnt_reg - MOD_CNT_W'(1);
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ src/blc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blc_dp #(
    parameter int BAR_STEPS = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  blc_pkg::dp_cmd_t              cmd,
    output blc_pkg::dp_status_t           status,
    input  blc_pkg::cfg_t                 cfg,
    input  logic                          period_wr,
    input  logic                          s_task_active,
    input  logic [blc_pkg::BTN_W-1:0]     s_button,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [blc_pkg::LED_W-1:0]     m_leds,
    output logic                          m_leds_valid,
    output logic [1:0]                    m_lock_phase,
    output logic                          m_locked,
    output logic                          m_code_match,
    output logic                          m_exit_request
);
    import blc_pkg::*;

    localparam int BAR_W = $clog2(BAR_STEPS + 1);
    localparam logic [BAR_W-1:0] BAR_FULL = BAR_W'(BAR_STEPS);

    // Bar bits from BAR_LSB upward, one per level.
    function automatic logic [LED_W-1:0] bar_pattern(input logic [BAR_W-1:0] level);
        logic [LED_W-1:0] bits;
        logic [BAR_W-1:0] lvl;
        lvl = (level > BAR_FULL) ? BAR_FULL : level;
        for (int i = 0; i < LED_W; i++) begin
            bits[i] = (i >= BAR_LSB) && ((i - BAR_LSB) < int'(lvl));
        end
        return bits;
    endfunction

    // Lock state.
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [BAR_W-1:0]  bar_reg, bar_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              locked_reg, locked_next;
    logic              held_a_reg, held_a_next;
    logic              held_b_reg, held_b_next;
    logic              held_y_reg, held_y_next;
    logic [LED_W-1:0]  led_reg, led_next;
    logic              stale_reg;

    // Current word.
    logic              act_reg;
    logic [BTN_W-1:0]  btn_reg;

    // Remainder unit.
    logic [TICK_W-1:0] div_rem_reg;
    logic [TICK_W-1:0] div_shift_reg;
    logic [TICK_W:0]   div_trial;
    logic [TICK_W:0]   div_diff;
    logic [TICK_W-1:0] div_step;

    // Output register.
    logic              m_valid_reg;
    logic [LED_W-1:0]  m_leds_reg;
    logic              m_leds_valid_reg;
    logic [1:0]        m_lock_phase_reg;
    logic              m_locked_reg;
    logic              m_code_match_reg;
    logic              m_exit_request_reg;

    // Helpers.
    logic [TICK_W-1:0] period_eff;
    logic              step_hit;
    logic [TICK_W-1:0] rem_plus;
    logic [TICK_W-1:0] rem_adv;
    logic [KEY_W-1:0]  seq_entries [CODE_ENTRIES];
    logic [KEY_W-1:0]  entry;
    logic [IDX_W:0]    len_eff;
    logic [IDX_W:0]    idx_plus;
    logic              press_en;
    logic [KEY_W-1:0]  press_key;
    logic              match;
    logic              exit_req;

    // A zero period counts as one.
    assign period_eff = (cfg.step_period == '0) ? TICK_W'(1) : cfg.step_period;
    assign step_hit   = (rem_reg == '0);
    assign rem_plus   = rem_reg + TICK_W'(1);

    // Remainder that follows the tick counter by one; the counter wraps to zero.
    assign rem_adv = (tick_reg == '1 || rem_plus == period_eff) ? '0 : rem_plus;

    // Shift-subtract step of the remainder rebuild.
    assign div_trial = {div_rem_reg, div_shift_reg[TICK_W-1]};
    assign div_diff  = div_trial - {1'b0, period_eff};
    assign div_step  = (div_trial >= {1'b0, period_eff}) ? div_diff[TICK_W-1:0]
                                                         : div_trial[TICK_W-1:0];

    // Code entries, entry 0 in the lowest bits.
    always_comb begin
        for (int i = 0; i < CODE_ENTRIES; i++) begin
            seq_entries[i] = cfg.code_sequence[KEY_W*i +: KEY_W];
        end
    end

    assign entry    = (idx_reg < IDX_W'(CODE_ENTRIES)) ? seq_entries[idx_reg] : KEY_A;
    assign idx_plus = {1'b0, idx_reg} + (IDX_W+1)'(1);

    // Effective code length: zero counts as one, long values saturate.
    always_comb begin
        if (cfg.code_length == '0) begin
            len_eff = (IDX_W+1)'(1);
        end else if (cfg.code_length > LEN_W'(CODE_MAX_LEN)) begin
            len_eff = (IDX_W+1)'(CODE_MAX_LEN);
        end else begin
            len_eff = (IDX_W+1)'(cfg.code_length);
        end
    end

    // Next state of one tick.
    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        rem_next    = rem_reg;
        bar_next    = bar_reg;
        idx_next    = idx_reg;
        locked_next = locked_reg;
        held_a_next = held_a_reg;
        held_b_next = held_b_reg;
        held_y_next = held_y_reg;
        led_next    = led_reg;
        press_en    = 1'b0;
        press_key   = KEY_A;
        match       = 1'b0;
        exit_req    = 1'b0;
        if (!act_reg) begin
            held_a_next = 1'b1;
            held_b_next = 1'b1;
            held_y_next = 1'b1;
        end else begin
            // Phase behavior and LED animation.
            case (phase_reg)
                PH_UNLOCKING: begin
                    locked_next = 1'b0;
                    if (step_hit) begin
                        led_next = cfg.base_led_mask | bar_pattern(bar_reg);
                        if (bar_reg != '0) begin
                            bar_next = bar_reg - BAR_W'(1);
                        end
                    end
                    if (tick_reg == cfg.unlock_duration) begin
                        phase_next = PH_UNLOCKED;
                        tick_next  = '0;
                        rem_next   = '0;
                    end else begin
                        tick_next = tick_reg + TICK_W'(1);
                        rem_next  = rem_adv;
                    end
                end
                PH_LOCKING: begin
                    if (step_hit) begin
                        led_next = cfg.base_led_mask | bar_pattern(bar_reg);
                        if (bar_reg < BAR_FULL) begin
                            bar_next = bar_reg + BAR_W'(1);
                        end
                    end
                    if (tick_reg == cfg.lock_duration) begin
                        phase_next = PH_LOCKED;
                        tick_next  = '0;
                        rem_next   = '0;
                    end else begin
                        tick_next = tick_reg + TICK_W'(1);
                        rem_next  = rem_adv;
                    end
                end
                PH_UNLOCKED: begin
                    locked_next = 1'b0;
                    bar_next    = '0;
                    led_next    = cfg.base_led_mask | bar_pattern('0);
                end
                default: begin
                    locked_next = 1'b1;
                    bar_next    = BAR_FULL;
                    led_next    = cfg.base_led_mask | bar_pattern(BAR_FULL);
                end
            endcase

            // Button decode; a press counts only on its first tick.
            case (btn_reg)
                BTN_X: begin
                    exit_req    = 1'b1;
                    tick_next   = '0;
                    rem_next    = '0;
                    held_a_next = 1'b0;
                    held_b_next = 1'b0;
                    held_y_next = 1'b0;
                end
                BTN_Y: begin
                    press_en    = !held_y_reg;
                    press_key   = KEY_Y;
                    held_a_next = 1'b0;
                    held_b_next = 1'b0;
                    held_y_next = 1'b1;
                end
                BTN_B: begin
                    press_en    = !held_b_reg;
                    press_key   = KEY_B;
                    held_a_next = 1'b1 ^ 1'b1;
                    held_b_next = 1'b1;
                    held_y_next = 1'b0;
                end
                BTN_A: begin
                    press_en    = !held_a_reg;
                    press_key   = KEY_A;
                    held_a_next = 1'b1;
                    held_b_next = 1'b0;
                    held_y_next = 1'b0;
                end
                default: begin
                    held_a_next = 1'b0;
                    held_b_next = 1'b0;
                    held_y_next = 1'b0;
                end
            endcase

            // Code match against the current entry.
            if (press_en) begin
                if (entry != press_key) begin
                    idx_next = '0;
                end else if (idx_plus >= len_eff) begin
                    idx_next = '0;
                    match    = 1'b1;
                end else begin
                    idx_next = idx_plus[IDX_W-1:0];
                end
            end

            // A full code toggles the lock.
            if (match) begin
                phase_next = locked_next ? PH_UNLOCKING : PH_LOCKING;
            end
        end
    end

    // Word capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= s_task_active;
            btn_reg <= s_button;
        end
    end

    // Remainder rebuild registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            div_rem_reg   <= '0;
            div_shift_reg <= tick_reg;
        end else if (cmd.mod_step) begin
            div_rem_reg   <= div_step;
            div_shift_reg <= {div_shift_reg[TICK_W-2:0], 1'b0};
        end
    end

    // Lock state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LOCKED;
            tick_reg   <= '0;
            rem_reg    <= '0;
            bar_reg    <= BAR_FULL;
            idx_reg    <= '0;
            locked_reg <= 1'b1;
            held_a_reg <= 1'b0;
            held_b_reg <= 1'b0;
            held_y_reg <= 1'b0;
            led_reg    <= RST_BASE_LED_MASK | bar_pattern(BAR_FULL);
            stale_reg  <= 1'b0;
        end else begin
            if (cmd.exec) begin
                phase_reg  <= phase_next;
                tick_reg   <= tick_next;
                rem_reg    <= rem_next;
                bar_reg    <= bar_next;
                idx_reg    <= idx_next;
                locked_reg <= locked_next;
                held_a_reg <= held_a_next;
                held_b_reg <= held_b_next;
                held_y_reg <= held_y_next;
                led_reg    <= led_next;
            end else if (cmd.mod_last) begin
                rem_reg <= div_step;
            end
            // A new period invalidates the tracked remainder.
            if (period_wr) begin
                stale_reg <= 1'b1;
            end else if (cmd.mod_last) begin
                stale_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_leds_reg         <= led_next;
            m_leds_valid_reg   <= act_reg;
            m_lock_phase_reg   <= phase_next;
            m_locked_reg       <= locked_next;
            m_code_match_reg   <= match;
            m_exit_request_reg <= exit_req;
        end
    end

    assign status.stale    = stale_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_leds         = m_leds_reg;
    assign m_leds_valid   = m_leds_valid_reg;
    assign m_lock_phase   = m_lock_phase_reg;
    assign m_locked       = m_locked_reg;
    assign m_code_match   = m_code_match_reg;
    assign m_exit_request = m_exit_request_reg;

endmodule

`default_nettype wire

@@ src/button_code_lock_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Button code lock controller. Each input word is one scheduler tick carrying the
// task-active flag and the pressed button; each tick returns exactly one result word
// with the LED pattern, the lock phase, the locked flag, a code-match flag and an
// exit request. New presses of A, B and Y are matched against the programmed code;
// a full match starts the animated unlocking or locking phase, in which the LED bar
// moves one step every step_period ticks. A tick first takes the word, then computes
// the result and loads the output register once that register is free; it holds the
// result while the next word is taken. The first tick after a write to step_period
// rebuilds the tick remainder against the new period before it computes, in a
// shift-subtract unit that resolves one bit per cycle. Registers sit at byte
// address 8*i: code_length, code_sequence, base_led_mask, step_period,
// unlock_duration, lock_duration; write them only while no tick is in flight.
module button_code_lock_controller #(
    parameter int BAR_STEPS = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Tick input.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_task_active,
    input  logic [blc_pkg::BTN_W-1:0]         s_button,
    // Result output.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [blc_pkg::LED_W-1:0]         m_leds,
    output logic                              m_leds_valid,
    output logic [1:0]                        m_lock_phase,
    output logic                              m_locked,
    output logic                              m_code_match,
    output logic                              m_exit_request,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [blc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [blc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [blc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import blc_pkg::*;

    cfg_t       cfg;
    logic       period_wr;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers.
    blc_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .period_wr (period_wr)
    );

    // Sequencer.
    blc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Lock state, remainder unit and output register.
    blc_dp #(
        .BAR_STEPS (BAR_STEPS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .period_wr      (period_wr),
        .s_task_active  (s_task_active),
        .s_button       (s_button),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_leds         (m_leds),
        .m_leds_valid   (m_leds_valid),
        .m_lock_phase   (m_lock_phase),
        .m_locked       (m_locked),
        .m_code_match   (m_code_match),
        .m_exit_request (m_exit_request)
    );

endmodule

`default_nettype wire

@@ src/blc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "button_code_lock_controller_macros.svh"

module blc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [blc_pkg::LED_W-1:0]     m_leds,
    input logic                          m_leds_valid,
    input logic [1:0]                    m_lock_phase,
    input logic                          m_locked,
    input logic                          m_code_match,
    input logic                          m_exit_request
);
    import blc_pkg::*;

    // A stalled result word holds.
    `BLC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_leds) && $stable(m_lock_phase))

    // One tick in flight: the block drops ready right after taking a word.
    `BLC_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // An inactive tick reports neither a match nor an exit.
    `BLC_ASSERT_NOW(a_idle_tick_quiet, m_valid && !m_leds_valid, !m_code_match && !m_exit_request)

    // A completed code always starts an animation.
    `BLC_ASSERT_NOW(a_match_animates, m_valid && m_code_match, m_lock_phase == PH_UNLOCKING || m_lock_phase == PH_LOCKING)

    // The unlocked phase never reports the badge as locked.
    `BLC_ASSERT_NOW(a_unlocked_flag, m_valid && m_lock_phase == PH_UNLOCKED, !m_locked)

endmodule

bind button_code_lock_controller blc_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_leds         (m_leds),
    .m_leds_valid   (m_leds_valid),
    .m_lock_phase   (m_lock_phase),
    .m_locked       (m_locked),
    .m_code_match   (m_code_match),
    .m_exit_request (m_exit_request)
);

`default_nettype wire

@@ verif/tb_button_code_lock_controller.sv @@
`timescale 1ns / 1ps

module tb_button_code_lock_controller;
    import blc_pkg::*;

    localparam int LOCK_BAR_STEPS = 5;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_TICKS   = 1300;
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int REPORT_LIMIT   = 100;

    // One result word as the block should return it.
    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic             leds_valid;
        phase_t           lock_phase;
        logic             locked;
        logic             code_match;
        logic             exit_request;
    } tick_word_t;

    typedef enum {CFG_LOWEST, CFG_HIGHEST, CFG_RANDOM} cfg_pick_t;
    typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_task_active;
    logic [BTN_W-1:0]      s_button;
    logic                  m_valid;
    logic                  m_ready;
    logic [LED_W-1:0]      m_leds;
    logic                  m_leds_valid;
    logic [1:0]            m_lock_phase;
    logic                  m_locked;
    logic                  m_code_match;
    logic                  m_exit_request;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Mirror of the lock: registers and state.
    cfg_t              lock_cfg;
    phase_t            lock_phase_q;
    logic [TICK_W-1:0] lock_tick_cnt;
    logic [2:0]        lock_bar;
    logic [IDX_W-1:0]  lock_idx;
    logic              lock_flag;
    logic              held_a;
    logic              held_b;
    logic              held_y;
    logic [LED_W-1:0]  lock_leds;

    tick_word_t lock_outcomes[$];
    tick_word_t arrived_want;

    // Run bookkeeping.
    logic     steady = 1'b0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_beat = 0;
    int       cycle_count = 0;
    int       failures = 0;
    int       ticks_sent = 0;
    int       words_checked = 0;
    int       matches_seen = 0;
    int       exits_seen = 0;
    int       settings_used = 0;
    logic [3:0] phases_seen = '0;

    button_code_lock_controller #(
        .BAR_STEPS(LOCK_BAR_STEPS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_task_active(s_task_active),
        .s_button(s_button),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_leds(m_leds),
        .m_leds_valid(m_leds_valid),
        .m_lock_phase(m_lock_phase),
        .m_locked(m_locked),
        .m_code_match(m_code_match),
        .m_exit_request(m_exit_request),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 aclk = ~aclk;

    // Base mask with the bar lit from bit 5 upward, level many LEDs.
    function automatic logic [LED_W-1:0] lit_pattern();
        logic [2:0] lvl;
        lvl = (lock_bar > LOCK_BAR_STEPS) ? 3'(LOCK_BAR_STEPS) : lock_bar;
        return lock_cfg.base_led_mask | (((16'd1 << lvl) - 16'd1) << BAR_LSB);
    endfunction

    // A code length of zero acts as one, and long codes saturate.
    function automatic int code_len_eff();
        int len;
        len = int'(lock_cfg.code_length);
        if (len == 0) len = 1;
        if (len > CODE_MAX_LEN) len = CODE_MAX_LEN;
        return len;
    endfunction

    function automatic logic [BTN_W-1:0] key_button(input logic [KEY_W-1:0] key);
        case (key)
            KEY_B: return BTN_B;
            KEY_Y: return BTN_Y;
            default: return BTN_A;
        endcase
    endfunction

    function automatic void reset_lock_model();
        lock_cfg.code_length     = RST_CODE_LENGTH;
        lock_cfg.code_sequence   = RST_CODE_SEQUENCE;
        lock_cfg.base_led_mask   = RST_BASE_LED_MASK;
        lock_cfg.step_period     = RST_STEP_PERIOD;
        lock_cfg.unlock_duration = RST_UNLOCK_DURATION;
        lock_cfg.lock_duration   = RST_LOCK_DURATION;
        lock_phase_q  = PH_LOCKED;
        lock_tick_cnt = '0;
        lock_bar      = 3'(LOCK_BAR_STEPS);
        lock_idx      = '0;
        lock_flag     = 1'b1;
        held_a        = 1'b0;
        held_b        = 1'b0;
        held_y        = 1'b0;
        lock_leds     = lit_pattern();
    endfunction

    // Match one key against the code entry at the current index.
    function automatic logic code_press(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] entry;
        entry = KEY_A;
        if (lock_idx < CODE_ENTRIES) entry = lock_cfg.code_sequence[2*lock_idx +: 2];
        if (entry != key) begin
            lock_idx = '0;
            return 1'b0;
        end
        if (int'(lock_idx) + 1 >= code_len_eff()) begin
            lock_idx = '0;
            return 1'b1;
        end
        lock_idx = lock_idx + 1'b1;
        return 1'b0;
    endfunction

    // Advance the lock by one tick and return the word it should produce.
    function automatic tick_word_t lock_tick(input logic act, input logic [BTN_W-1:0] btn);
        tick_word_t        w;
        logic [TICK_W-1:0] period;
        logic              hit;
        hit = 1'b0;
        w.exit_request = 1'b0;
        w.leds_valid = act;
        if (!act) begin
            held_a = 1'b1;
            held_b = 1'b1;
            held_y = 1'b1;
        end else begin
            period = (lock_cfg.step_period == '0) ? 16'd1 : lock_cfg.step_period;
            case (lock_phase_q)
                PH_UNLOCKING: begin
                    lock_flag = 1'b0;
                    if (lock_tick_cnt % period == '0) begin
                        lock_leds = lit_pattern();
                        if (lock_bar > 0) lock_bar = lock_bar - 1'b1;
                    end
                    if (lock_tick_cnt == lock_cfg.unlock_duration) begin
                        lock_phase_q = PH_UNLOCKED;
                        lock_tick_cnt = '0;
                    end else begin
                        lock_tick_cnt = lock_tick_cnt + 1'b1;
                    end
                end
                PH_LOCKING: begin
                    if (lock_tick_cnt % period == '0) begin
                        lock_leds = lit_pattern();
                        if (lock_bar < LOCK_BAR_STEPS) lock_bar = lock_bar + 1'b1;
                    end
                    if (lock_tick_cnt == lock_cfg.lock_duration) begin
                        lock_phase_q = PH_LOCKED;
                        lock_tick_cnt = '0;
                    end else begin
                        lock_tick_cnt = lock_tick_cnt + 1'b1;
                    end
                end
                PH_UNLOCKED: begin
                    lock_flag = 1'b0;
                    lock_bar = '0;
                    lock_leds = lit_pattern();
                end
                default: begin
                    lock_flag = 1'b1;
                    lock_bar = 3'(LOCK_BAR_STEPS);
                    lock_leds = lit_pattern();
                end
            endcase

            // Only a fresh press of A, B or Y counts; X clears the tick counter.
            case (btn)
                BTN_X: begin
                    w.exit_request = 1'b1;
                    lock_tick_cnt = '0;
                    held_a = 1'b0;
                    held_b = 1'b0;
                    held_y = 1'b0;
                end
                BTN_Y: begin
                    if (!held_y) hit = code_press(KEY_Y);
                    held_a = 1'b0;
                    held_b = 1'b0;
                    held_y = 1'b1;
                end
                BTN_B: begin
                    if (!held_b) hit = code_press(KEY_B);
                    held_a = 1'b0;
                    held_b = 1'b1;
                    held_y = 1'b0;
                end
                BTN_A: begin
                    if (!held_a) hit = code_press(KEY_A);
                    held_a = 1'b1;
                    held_b = 1'b0;
                    held_y = 1'b0;
                end
                default: begin
                    held_a = 1'b0;
                    held_b = 1'b0;
                    held_y = 1'b0;
                end
            endcase
            if (hit) lock_phase_q = lock_flag ? PH_UNLOCKING : PH_LOCKING;
        end
        w.leds = lock_leds;
        w.lock_phase = lock_phase_q;
        w.locked = lock_flag;
        w.code_match = hit;
        phases_seen[lock_phase_q] = 1'b1;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Send one tick word; the sender idles in bursts unless the run is steady.
    task automatic send_tick(input logic act, input logic [BTN_W-1:0] btn);
        int gap;
        if (!steady && burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_task_active = act;
        s_button = btn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lock_outcomes.push_back(lock_tick(act, btn));
        ticks_sent++;
    endtask

    // Let go of the buttons, sometimes through an inactive tick or an unused code.
    task automatic send_release();
        if ($urandom_range(0, 5) == 0) send_tick(1'b0, 3'($urandom_range(0, 7)));
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) == 0) send_tick(1'b1, 3'($urandom_range(5, 7)));
            else send_tick(1'b1, BTN_NONE);
        end
    endtask

    // Key in the rest of the code from the current index; one press may be wrong.
    task automatic enter_code(input int break_at);
        int               i;
        int               n;
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] other;
        send_release();
        i = int'(lock_idx);
        n = 0;
        do begin
            btn = key_button(lock_cfg.code_sequence[2*i +: 2]);
            if (n == break_at) begin
                do other = key_button(2'($urandom_range(0, 2)));
                while (other == btn);
                btn = other;
            end
            send_tick(1'b1, btn);
            send_release();
            i++;
            n++;
        end while (i < code_len_eff());
    endtask

    // Wait until every word has come back and the block has gone quiet.
    task automatic quiesce();
        @(negedge aclk);
        s_valid = 1'b0;
        while (lock_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        logic [63:0] want;
        logic [63:0] got;
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_CODE_LENGTH: begin
                lock_cfg.code_length = value[LEN_W-1:0];
                want = 64'(lock_cfg.code_length);
            end
            REG_CODE_SEQUENCE: begin
                lock_cfg.code_sequence = value[SEQ_W-1:0];
                want = 64'(lock_cfg.code_sequence);
            end
            REG_BASE_LED_MASK: begin
                lock_cfg.base_led_mask = value[LED_W-1:0];
                want = 64'(lock_cfg.base_led_mask);
            end
            REG_STEP_PERIOD: begin
                lock_cfg.step_period = value[TICK_W-1:0];
                want = 64'(lock_cfg.step_period);
            end
            REG_UNLOCK_DURATION: begin
                lock_cfg.unlock_duration = value[TICK_W-1:0];
                want = 64'(lock_cfg.unlock_duration);
            end
            default: begin
                lock_cfg.lock_duration = value[TICK_W-1:0];
                want = 64'(lock_cfg.lock_duration);
            end
        endcase
        @(negedge aclk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        check_field("register readback", want, got);
    endtask

    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 25) return 16'hFFFF;
        if (r < 40) return 16'($urandom());
        return 16'($urandom_range(1, 30));
    endfunction

    // Program all six registers for the next stretch of the run.
    task automatic program_lock(input cfg_pick_t pick);
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [LED_W-1:0]  mask;
        logic [TICK_W-1:0] step;
        int                i;
        int                r;
        quiesce();
        for (i = 0; i < CODE_ENTRIES; i++) seq[2*i +: 2] = 2'($urandom_range(0, 2));
        case (pick)
            CFG_LOWEST: begin
                len = 5'd1;
                seq = '0;
                mask = 16'h0000;
                step = 16'd1;
            end
            CFG_HIGHEST: begin
                len = 5'd31;
                mask = 16'hFFFF;
                step = 16'hFFFF;
            end
            default: begin
                if ($urandom_range(0, 4) == 0) seq = {$urandom(), 8'($urandom())};
                r = $urandom_range(0, 99);
                if (r < 60) len = LEN_W'($urandom_range(1, 6));
                else if (r < 85) len = LEN_W'($urandom_range(7, 20));
                else if (r < 90) len = '0;
                else len = LEN_W'($urandom_range(21, 31));
                r = $urandom_range(0, 9);
                mask = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
                r = $urandom_range(0, 99);
                if (r < 50) step = 16'($urandom_range(1, 4));
                else if (r < 65) step = 16'd0;
                else if (r < 80) step = 16'($urandom_range(5, 20));
                else if (r < 90) step = 16'hFFFF;
                else step = 16'($urandom());
            end
        endcase
        write_reg(REG_CODE_LENGTH, 64'(len));
        write_reg(REG_CODE_SEQUENCE, 64'(seq));
        write_reg(REG_BASE_LED_MASK, 64'(mask));
        write_reg(REG_STEP_PERIOD, 64'(step));
        if (pick == CFG_LOWEST) begin
            write_reg(REG_UNLOCK_DURATION, 64'd0);
            write_reg(REG_LOCK_DURATION, 64'd0);
        end else if (pick == CFG_HIGHEST) begin
            write_reg(REG_UNLOCK_DURATION, 64'hFFFF);
            write_reg(REG_LOCK_DURATION, 64'hFFFF);
        end else begin
            write_reg(REG_UNLOCK_DURATION, 64'(pick_duration()));
            write_reg(REG_LOCK_DURATION, 64'(pick_duration()));
        end
        settings_used++;
    endtask

    // Reset pattern, inactive ticks, unused button codes, X and a wrong press.
    task automatic test_reset_and_buttons();
        send_tick(1'b0, BTN_NONE);
        send_tick(1'b1, BTN_NONE);
        send_tick(1'b1, 3'd5);
        send_tick(1'b1, 3'd6);
        send_tick(1'b1, 3'd7);
        send_tick(1'b1, BTN_X);
        send_tick(1'b1, BTN_A);
    endtask

    // Reset code, a held button that must not count, then unlock and relock.
    task automatic test_default_code();
        send_tick(1'b1, BTN_Y);
        send_tick(1'b1, BTN_Y);
        send_tick(1'b1, BTN_B);
        send_tick(1'b1, BTN_Y);
        send_tick(1'b1, BTN_A);
        quiesce();
        write_reg(REG_STEP_PERIOD, 64'd0);
        write_reg(REG_UNLOCK_DURATION, 64'd3);
        write_reg(REG_LOCK_DURATION, 64'd0);
        settings_used++;
        repeat (6) send_tick(1'b1, BTN_NONE);
        enter_code(-1);
    endtask

    // Zero code length, an unmatchable code, and an index left past a shorter length.
    task automatic test_code_edges();
        quiesce();
        write_reg(REG_CODE_LENGTH, 64'd0);
        write_reg(REG_CODE_SEQUENCE, 64'(KEY_B));
        send_release();
        send_tick(1'b1, BTN_B);
        quiesce();
        write_reg(REG_CODE_SEQUENCE, {24'd0, 40'hFF_FFFF_FFFF});
        send_tick(1'b1, BTN_A);
        send_tick(1'b1, BTN_B);
        send_tick(1'b1, BTN_Y);
        quiesce();
        write_reg(REG_CODE_LENGTH, 64'd6);
        write_reg(REG_CODE_SEQUENCE,
                  64'({KEY_Y, KEY_B, KEY_A, KEY_Y, KEY_B, KEY_A}));
        send_tick(1'b1, BTN_NONE);
        send_tick(1'b1, BTN_A);
        send_tick(1'b1, BTN_B);
        send_tick(1'b1, BTN_Y);
        send_tick(1'b1, BTN_A);
        quiesce();
        write_reg(REG_CODE_LENGTH, 64'd2);
        send_tick(1'b1, BTN_B);
        settings_used += 3;
    endtask

    // Push the tick counter past the unlock duration; it keeps counting until X clears it.
    task automatic test_tick_wrap();
        quiesce();
        steady = 1'b1;
        write_reg(REG_CODE_LENGTH, 64'd1);
        write_reg(REG_CODE_SEQUENCE, 64'(KEY_A));
        write_reg(REG_STEP_PERIOD, 64'd1);
        write_reg(REG_UNLOCK_DURATION, 64'd0);
        write_reg(REG_LOCK_DURATION, 64'd0);
        while (lock_phase_q != PH_LOCKED) begin
            if (lock_phase_q == PH_UNLOCKED) enter_code(-1);
            else send_tick(1'b1, BTN_X);
        end
        quiesce();
        write_reg(REG_UNLOCK_DURATION, 64'd100);
        write_reg(REG_STEP_PERIOD, 64'hFFFF);
        enter_code(-1);
        while (lock_tick_cnt < 50) send_tick(1'b1, BTN_NONE);
        quiesce();
        write_reg(REG_UNLOCK_DURATION, 64'd10);
        repeat (20) send_tick($urandom_range(0, 15) != 0, BTN_NONE);
        send_tick(1'b1, BTN_X);
        while (lock_phase_q == PH_UNLOCKING)
            send_tick($urandom_range(0, 15) != 0, BTN_NONE);
        steady = 1'b0;
        settings_used += 3;
    endtask

    // Mostly code entries with random content, mixed with noise, X and waits.
    task automatic test_random_ticks();
        int start;
        int stretch;
        int target;
        int pick;
        int n;
        start = ticks_sent;
        n = 0;
        while (ticks_sent - start < RANDOM_TICKS) begin
            program_lock(n == 0 ? CFG_LOWEST : n == 1 ? CFG_HIGHEST : CFG_RANDOM);
            stretch = ticks_sent;
            target = $urandom_range(150, 300);
            while (ticks_sent - stretch < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    enter_code(-1);
                end else if (pick < 70) begin
                    enter_code($urandom_range(0, code_len_eff() - 1));
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 10))
                        send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
                end else if (pick < 92) begin
                    send_tick(1'b1, BTN_X);
                end else if (pick < 98) begin
                    repeat ($urandom_range(5, 50)) send_tick(1'b1, BTN_NONE);
                end else begin
                    quiesce();
                end
            end
            n++;
        end
    endtask

    // Result side stalls on its own changing pattern.
    always @(negedge aclk) begin
        if (steady || !aresetn) begin
            m_ready = 1'b1;
        end else begin
            if (rx_left <= 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            rx_beat++;
            case (rx_mode)
                RX_OPEN: m_ready = 1'b1;
                RX_COIN: m_ready = 1'($urandom_range(0, 1));
                RX_SLOW: m_ready = ($urandom_range(0, 5) == 0);
                default: m_ready = (rx_beat % 3 == 0);
            endcase
        end
    end

    // Compare each accepted result word with the oldest outstanding tick.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lock_outcomes.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $error("result word arrived with no tick outstanding");
            end else begin
                arrived_want = lock_outcomes.pop_front();
                words_checked++;
                if (arrived_want.code_match) matches_seen++;
                if (arrived_want.exit_request) exits_seen++;
                check_field("leds", 64'(arrived_want.leds), 64'(m_leds));
                check_field("leds_valid", 64'(arrived_want.leds_valid), 64'(m_leds_valid));
                check_field("lock_phase", 64'(arrived_want.lock_phase), 64'(m_lock_phase));
                check_field("locked", 64'(arrived_want.locked), 64'(m_locked));
                check_field("code_match", 64'(arrived_want.code_match), 64'(m_code_match));
                check_field("exit_request", 64'(arrived_want.exit_request),
                            64'(m_exit_request));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("button_code_lock_controller verification failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_task_active = 1'b0;
        s_button = BTN_NONE;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_lock_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_and_buttons();
        test_default_code();
        test_code_edges();
        test_tick_wrap();
        test_random_ticks();
        quiesce();

        $display("Run covered %0d ticks under %0d register settings, %0d words checked.",
                 ticks_sent, settings_used, words_checked);
        $display("Code matches %0d, exit requests %0d, lock phases reached %b.",
                 matches_seen, exits_seen, phases_seen);
        if (failures == 0 && lock_outcomes.size() == 0) begin
            $display("button_code_lock_controller verification clean");
        end else begin
            $display("button_code_lock_controller verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/blc_pkg.sv
src/blc_regs.sv
src/blc_ctrl.sv
src/blc_dp.sv
src/button_code_lock_controller.sv
src/blc_checker.sv
verif/tb_button_code_lock_controller.sv
